FILE: hw/rtl/limit_order_book_matcher_assert.svh
// Assertion macros used by the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// Antecedent implies consequent on the next clock, outside reset.
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition holds at every clock outside reset.
`define LOBM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/lobm_pkg.sv
package lobm_pkg;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_TRADE  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic        is_buy;
    logic [15:0] limit_price;
    logic [15:0] order_qty;
    logic [31:0] order_ident;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] buy_ident;
    logic [31:0] sell_ident;
    logic [15:0] trade_qty;
    logic [15:0] trade_price;
    logic        last;
  } out_item_t;

  // One stored order.
  typedef struct packed {
    logic        is_buy;
    logic [15:0] price;
    logic [15:0] remaining;
    logic [31:0] ident;
    logic [31:0] arrival;
  } slot_t;

  // Result of one scan step over the book.
  typedef struct packed {
    logic        found;
    logic [15:0] price;
    logic [31:0] arrival;
  } best_t;

  // True when candidate c beats the current pick p on side buy.
  function automatic logic beats(input logic buy, input slot_t c, input best_t p);
    logic r;
    if (!p.found) r = 1'b1;
    else if (c.price != p.price) r = buy ? (c.price > p.price) : (c.price < p.price);
    else r = c.arrival < p.arrival;
    return r;
  endfunction

endpackage

FILE: hw/rtl/lobm_slot_ram.sv
module lobm_slot_ram #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  lobm_pkg::slot_t      wdata,
  input  logic [AW-1:0]        raddr,
  output lobm_pkg::slot_t      rdata
);

  lobm_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/limit_order_book_matcher.sv
// Price-time priority limit order book.
// Input channel in_valid/in_ready/in_data carries add and match commands;
// output channel out_valid/out_ready/out_data carries results, last marks the
// final result of a command. There is no configuration port.
// An add finds the lowest free slot from the valid flags combinationally and
// writes the order into the slot memory: one result, made valid from state
// S_ADD after the transfer. A match runs rounds: each round scans every slot
// memory entry twice (buy side, then sell side), one read per cycle; a round
// in which the best buy price reaches the best sell price then reads both
// picked slots back, updates quantities and emits one trade. The slot memory
// has a single read port. One command is worked on at a time.
// A result is held in an output register; while the receiver stalls, the
// block runs on only up to the point where it needs that register again.
// A synchronous active-low reset empties the book (valid flags cleared) and
// zeroes the arrival counter; memory contents are not cleared.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_item_t out_data
);

  localparam int AW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCANB = 10'b0000000010,
    S_SCANS = 10'b0000000100,
    S_RDB   = 10'b0000001000,
    S_RDS   = 10'b0000010000,
    S_WAITS = 10'b0000100000,
    S_WRB   = 10'b0001000000,
    S_WRS   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_ADD   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0] arrival_r, arrival_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // scan issue counter
  logic [AW-1:0] bidx_r, bidx_nxt, sidx_r, sidx_nxt;
  logic [AW-1:0] cidx_r, cidx_nxt;    // index of the entry whose data returns
  logic          cval_r, cval_nxt;    // data returning this cycle is a scan read
  lobm_pkg::best_t best_r, best_nxt;
  lobm_pkg::slot_t bslot_r, bslot_nxt, sslot_r, sslot_nxt;
  logic          ntrade_r, ntrade_nxt; // set once a trade has been issued in this match
  logic          bfound_r, bfound_nxt;
  logic [15:0]   bprice_r, bprice_nxt;
  logic          fin_r, fin_nxt;
  lobm_pkg::out_item_t out_r, out_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  lobm_pkg::slot_t wdata, rdata;

  lobm_slot_ram #(.DEPTH(ORDER_SLOTS), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic          free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [15:0] q;
  assign q = (bslot_r.remaining < sslot_r.remaining) ? bslot_r.remaining
                                                     : sslot_r.remaining;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    arrival_nxt = arrival_r;
    cnt_nxt = cnt_r;
    bidx_nxt = bidx_r;
    sidx_nxt = sidx_r;
    cidx_nxt = cidx_r;
    cval_nxt = 1'b0;
    best_nxt = best_r;
    bslot_nxt = bslot_r;
    sslot_nxt = sslot_r;
    ntrade_nxt = ntrade_r;
    bfound_nxt = bfound_r;
    bprice_nxt = bprice_r;
    fin_nxt = fin_r;
    out_nxt = out_r;
    ovalid_nxt = ovalid_r;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    // A scan read's data arrives in the cycle after its address.
    if (cval_r && valid_r[cidx_r] && rdata.is_buy == state_r[1]
        && lobm_pkg::beats(state_r[1], rdata, best_r)) begin
      best_nxt.found = 1'b1;
      best_nxt.price = rdata.price;
      best_nxt.arrival = rdata.arrival;
      if (state_r[1]) bidx_nxt = cidx_r;
      else sidx_nxt = cidx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_nxt = '0;
          out_nxt.last = 1'b1;
          if (in_data.cmd == lobm_pkg::CMD_ADD) begin
            if (free_found) begin
              we = 1'b1;
              waddr = free_idx;
              wdata.is_buy = in_data.is_buy;
              wdata.price = in_data.limit_price;
              wdata.remaining = in_data.order_qty;
              wdata.ident = in_data.order_ident;
              wdata.arrival = arrival_r;
              valid_nxt[free_idx] = 1'b1;
              arrival_nxt = arrival_r + 32'd1;
              out_nxt.kind = lobm_pkg::KIND_ACCEPT;
            end else begin
              out_nxt.kind = lobm_pkg::KIND_FULL;
            end
            state_nxt = S_ADD;
          end else begin
            ntrade_nxt = 1'b0;
            cnt_nxt = '0;
            best_nxt = '0;
            state_nxt = S_SCANB;
          end
        end
      end
      S_ADD: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCANB, S_SCANS: begin
        if (cnt_r < CW'(ORDER_SLOTS)) begin
          raddr = cnt_r[AW-1:0];
          cidx_nxt = cnt_r[AW-1:0];
          cval_nxt = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else if (!cval_r) begin
          cnt_nxt = '0;
          if (state_r == S_SCANB) begin
            bfound_nxt = best_r.found;
            bprice_nxt = best_r.price;
            best_nxt = '0;
            state_nxt = S_SCANS;
          end else if (bfound_r && best_r.found && bprice_r >= best_r.price
                       && !(ntrade_r && fin_r)) begin
            state_nxt = S_RDB;
          end else begin
            fin_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_RDB: begin
        raddr = bidx_r;
        state_nxt = S_RDS;
      end
      S_RDS: begin
        raddr = sidx_r;
        bslot_nxt = rdata;
        state_nxt = S_WAITS;
      end
      S_WAITS: begin
        sslot_nxt = rdata;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        we = 1'b1;
        waddr = bidx_r;
        wdata = bslot_r;
        wdata.remaining = bslot_r.remaining - q;
        if (bslot_r.remaining == q) valid_nxt[bidx_r] = 1'b0;
        state_nxt = S_WRS;
      end
      S_WRS: begin
        // The new trade may only enter the output register once the one
        // emitted before it has been transferred.
        if (!ovalid_r || out_ready) begin
          we = 1'b1;
          waddr = sidx_r;
          wdata = sslot_r;
          wdata.remaining = sslot_r.remaining - q;
          if (sslot_r.remaining == q) valid_nxt[sidx_r] = 1'b0;
          out_nxt.kind = lobm_pkg::KIND_TRADE;
          out_nxt.buy_ident = bslot_r.ident;
          out_nxt.sell_ident = sslot_r.ident;
          out_nxt.trade_qty = q;
          out_nxt.trade_price = sslot_r.price;
          out_nxt.last = 1'b0;
          fin_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // The previous trade is held until the next round decides whether it
        // is the last result of the match.
        if (!ovalid_r || out_ready) begin
          if (fin_r) begin
            if (ntrade_r) begin
              out_nxt.last = 1'b1;
            end else begin
              out_nxt = '0;
              out_nxt.kind = lobm_pkg::KIND_NONE;
              out_nxt.last = 1'b1;
            end
            ovalid_nxt = 1'b1;
            fin_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            ntrade_nxt = 1'b1;
            cnt_nxt = '0;
            best_nxt = '0;
            state_nxt = S_SCANB;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Emit the pending trade once the next round shows it is not the last one.
    if (state_r == S_SCANS && state_nxt == S_RDB && ntrade_r) begin
      ovalid_nxt = 1'b1;
    end
  end

  // A pending trade must wait for the output register to be free first.
  logic stall_emit;
  assign stall_emit = (state_r == S_SCANS) && (state_nxt == S_RDB) && ntrade_r
                      && ovalid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      arrival_r <= '0;
      ovalid_r <= 1'b0;
      cval_r <= 1'b0;
      fin_r <= 1'b0;
      ntrade_r <= 1'b0;
    end else if (!stall_emit) begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      arrival_r <= arrival_nxt;
      ovalid_r <= ovalid_nxt;
      cval_r <= cval_nxt;
      fin_r <= fin_nxt;
      ntrade_r <= ntrade_nxt;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_emit) begin
      cnt_r <= cnt_nxt;
      bidx_r <= bidx_nxt;
      sidx_r <= sidx_nxt;
      cidx_r <= cidx_nxt;
      best_r <= best_nxt;
      bslot_r <= bslot_nxt;
      sslot_r <= sslot_nxt;
      bfound_r <= bfound_nxt;
      bprice_r <= bprice_nxt;
      out_r <= out_nxt;
    end
  end

  // When the buy order survives a trade, the sell order must be the one used up.
  logic trade_empties;
  assign trade_empties = !valid_r[bidx_r] || (sslot_r.remaining == q);

`include "limit_order_book_matcher_assert.svh"

  `LOBM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `LOBM_ASSERT_ALWAYS(a_busy_no_in, clk, rst_n, !(in_ready && state_r != S_IDLE))
  `LOBM_ASSERT_ALWAYS(a_trade_frees, clk, rst_n, state_r != S_WRS || trade_empties)

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 2000000;

  // Order book predictor with a queue of expected results.
  class book_scoreboard;
    bit          live[SLOTS];
    bit          side_buy[SLOTS];
    logic [15:0] price[SLOTS];
    logic [15:0] left_qty[SLOTS];
    logic [31:0] ident[SLOTS];
    logic [31:0] arrival[SLOTS];
    logic [31:0] arrival_count;
    lobm_pkg::out_item_t pending[$];
    int          mismatches;
    int          trades_seen;
    int          fulls_seen;

    function void clear();
      foreach (live[i]) live[i] = 0;
      arrival_count = 0;
      pending.delete();
    endfunction

    function int best_on(bit buy);
      int pick;
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!live[i] || side_buy[i] != buy) continue;
        if (pick < 0) pick = i;
        else if (price[i] != price[pick]) begin
          if (buy ? (price[i] > price[pick]) : (price[i] < price[pick])) pick = i;
        end else if (arrival[i] < arrival[pick]) pick = i;
      end
      return pick;
    endfunction

    function void note_input(lobm_pkg::in_item_t it);
      lobm_pkg::out_item_t r;
      int slot;
      int b;
      int s;
      int n;
      logic [15:0] q;
      r = '0;
      r.last = 1'b1;
      if (it.cmd == lobm_pkg::CMD_ADD) begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.kind = lobm_pkg::KIND_FULL;
        end else begin
          live[slot] = 1;
          side_buy[slot] = it.is_buy;
          price[slot] = it.limit_price;
          left_qty[slot] = it.order_qty;
          ident[slot] = it.order_ident;
          arrival[slot] = arrival_count;
          arrival_count++;
          r.kind = lobm_pkg::KIND_ACCEPT;
        end
        pending.push_back(r);
        return;
      end
      n = 0;
      forever begin
        b = best_on(1);
        s = best_on(0);
        if (b < 0 || s < 0 || price[b] < price[s] || n >= 64) break;
        q = (left_qty[b] < left_qty[s]) ? left_qty[b] : left_qty[s];
        r = '0;
        r.kind = lobm_pkg::KIND_TRADE;
        r.buy_ident = ident[b];
        r.sell_ident = ident[s];
        r.trade_qty = q;
        r.trade_price = price[s];
        pending.push_back(r);
        n++;
        left_qty[b] -= q;
        left_qty[s] -= q;
        if (left_qty[b] == 0) live[b] = 0;
        if (left_qty[s] == 0) live[s] = 0;
      end
      if (n == 0) begin
        r = '0;
        r.kind = lobm_pkg::KIND_NONE;
        r.last = 1'b1;
        pending.push_back(r);
      end else begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(lobm_pkg::out_item_t got);
      lobm_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.kind == lobm_pkg::KIND_TRADE) trades_seen++;
      if (got.kind == lobm_pkg::KIND_FULL) fulls_seen++;
      if (got.kind !== want.kind || got.buy_ident !== want.buy_ident ||
          got.sell_ident !== want.sell_ident || got.trade_qty !== want.trade_qty ||
          got.trade_price !== want.trade_price || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  lobm_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lobm_pkg::out_item_t out_data;

  book_scoreboard book;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int cycles;
  int items_sent;

  limit_order_book_matcher #(.ORDER_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: checks each transfer and draws a new ready per cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) book.check_result(out_data);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays up after a transfer so that items can follow back to back; it
  // drops in the idle cycles before the next item or when draining.
  task automatic send_item(lobm_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_input(it);
    items_sent++;
  endtask

  task automatic add_order(bit buy, logic [15:0] px, logic [15:0] qty, logic [31:0] id);
    lobm_pkg::in_item_t it;
    it.cmd = lobm_pkg::CMD_ADD;
    it.is_buy = buy;
    it.limit_price = px;
    it.order_qty = qty;
    it.order_ident = id;
    send_item(it);
  endtask

  task automatic run_match();
    lobm_pkg::in_item_t it;
    it.cmd = lobm_pkg::CMD_MATCH;
    it.is_buy = 1'($urandom_range(1));
    it.limit_price = 16'($urandom);
    it.order_qty = 16'($urandom);
    it.order_ident = $urandom;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(9) < 3) begin
        run_match();
      end else begin
        // Prices clustered so books cross often; some full-range values.
        add_order(1'($urandom_range(1)), ($urandom_range(4) == 0) ? 16'($urandom) :
                  16'(1000 + $urandom_range(20)),
                  ($urandom_range(9) == 0) ? 16'($urandom_range(1)) : 16'($urandom),
                  $urandom);
      end
      k++;
    end
  endtask

  initial begin
    book = new();
    book.clear();
    book.mismatches = 0;
    book.trades_seen = 0;
    book.fulls_seen = 0;
    cycles = 0;
    items_sent = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty match, zero qty, extremes, time priority, book full.
    run_match();
    add_order(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    add_order(1'b0, 16'h0000, 16'hFFFF, 32'h0);
    run_match();
    add_order(1'b1, 16'd100, 16'd5, 32'd11);
    add_order(1'b1, 16'd100, 16'd7, 32'd12);
    add_order(1'b0, 16'd99, 16'd9, 32'd21);
    add_order(1'b0, 16'd101, 16'd3, 32'd22);
    run_match();
    run_match();
    for (int i = 0; i < 34; i++) add_order(i[0], 16'(200 + i), 16'd1, 32'(100 + i));
    run_match();
    drain();

    send_idle_pct = 0;  recv_idle_pct = 0;  random_phase(70);
    send_idle_pct = 67; recv_idle_pct = 0;  random_phase(60);
    send_idle_pct = 0;  recv_idle_pct = 67; random_phase(60);
    send_idle_pct = 28; recv_idle_pct = 28; random_phase(60);

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0;  recv_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20);
    join
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d items; saw %0d trades and %0d book-full rejects",
             items_sent, book.trades_seen, book.fulls_seen);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding",
               book.mismatches, book.pending.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_slot_ram.sv
hw/rtl/limit_order_book_matcher.sv
tb/sv/tb_top.sv
